// ===== src/frame_reassembler_rx_assert.svh =====
// Assertion macros used by the frame reassembler checker.
`ifndef FRAME_REASSEMBLER_RX_ASSERT_SVH
`define FRAME_REASSEMBLER_RX_ASSERT_SVH

// Checks a consequence in the same cycle as its cause.
`define FRA_ASSERT_SAME(lbl, cause, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (cons)) \
    else $error("fra_checker: same-cycle check failed");

// Checks a consequence in the cycle after its cause.
`define FRA_ASSERT_NEXT(lbl, cause, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (cons)) \
    else $error("fra_checker: next-cycle check failed");

`endif

// ===== src/fra_pkg.sv =====
// Types and constants of the frame reassembler.
package fra_pkg;

  localparam int HDR_BYTES = 12;
  localparam int HDR_IDX_W = 4;

  localparam logic [1:0] ST_MORE  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTO_VER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TYPE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT  = 3'd4;
  localparam logic [15:0] FRAME_LIMIT_RST = 16'd1536;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       packet_last;
  } in_item_t;

  typedef struct packed {
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [15:0] data_offset;
    logic        run_last;
    logic [1:0]  status;
    logic [15:0] frame_length;
    logic [15:0] frame_flags;
    logic [31:0] frame_seq;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  magic_first;
    logic [7:0]  magic_second;
    logic [7:0]  proto_version;
    logic [7:0]  frame_type;
    logic [15:0] frame_limit;
  } cfg_t;

  typedef struct packed {
    logic [HDR_BYTES-1:0][7:0] hdr;
    logic                      overlong;
    logic                      bank;
  } desc_t;

endpackage

// ===== src/fra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fra_ram import fra_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/fra_front.sv =====
// Front end: stores packet bytes into the current bank and hands finished packets on.
module fra_front import fra_pkg::*; #(
  parameter int PACKET_BYTES = 64,
  parameter int CW = $clog2(PACKET_BYTES + 1),
  parameter int AW = $clog2(2 * PACKET_BYTES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  in_item_t      in_data,
  input  logic          q_full,
  output logic          q_push,
  output desc_t         q_desc,
  output logic [CW-1:0] q_count,
  output logic          ram_wr_en,
  output logic [AW-1:0] ram_wr_addr,
  output logic [7:0]    ram_wr_data
);

  logic [CW-1:0]             wr_idx_r, wr_idx_nxt;
  logic                      ovl_r, ovl_nxt;
  logic                      bank_r, bank_nxt;
  logic [HDR_BYTES-1:0][7:0] hdr_r, hdr_nxt;
  logic                      accept;
  logic                      store;
  logic [CW-1:0]             cnt_pkt;
  logic                      ovl_pkt;

  assign accept = in_push && !q_full;
  assign store  = wr_idx_r < CW'(PACKET_BYTES);

  always_comb begin
    hdr_nxt = hdr_r;
    if (accept && store && (wr_idx_r < CW'(HDR_BYTES))) begin
      hdr_nxt[wr_idx_r[HDR_IDX_W-1:0]] = in_data.packet_byte;
    end
  end

  assign cnt_pkt = store ? wr_idx_r + CW'(1) : wr_idx_r;
  assign ovl_pkt = ovl_r || !store;

  always_comb begin
    wr_idx_nxt = wr_idx_r;
    ovl_nxt    = ovl_r;
    bank_nxt   = bank_r;
    if (accept) begin
      if (in_data.packet_last) begin
        wr_idx_nxt = '0;
        ovl_nxt    = 1'b0;
        bank_nxt   = !bank_r;
      end else begin
        wr_idx_nxt = cnt_pkt;
        ovl_nxt    = ovl_pkt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      ovl_r    <= 1'b0;
      bank_r   <= 1'b0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      ovl_r    <= ovl_nxt;
      bank_r   <= bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

  assign ram_wr_en   = accept && store;
  assign ram_wr_addr = bank_r ? AW'(PACKET_BYTES) + AW'(wr_idx_r) : AW'(wr_idx_r);
  assign ram_wr_data = in_data.packet_byte;

  assign q_push        = accept && in_data.packet_last;
  assign q_desc.hdr      = hdr_nxt;
  assign q_desc.overlong = ovl_pkt;
  assign q_desc.bank     = bank_r;
  assign q_count       = cnt_pkt;

endmodule

// ===== src/fra_desc_queue.sv =====
// Two-entry queue of finished packet descriptors, one entry per buffer bank.
module fra_desc_queue import fra_pkg::*; #(
  parameter int CW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  desc_t         push_desc,
  input  logic [CW-1:0] push_count,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output desc_t         head_desc,
  output logic [CW-1:0] head_count
);

  desc_t         desc_r [2];
  logic [CW-1:0] cnt_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    used_r, used_nxt;
  logic          do_push, do_pop;

  assign full    = used_r == 2'd2;
  assign valid   = used_r != 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    used_nxt   = used_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      used_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      used_r   <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      desc_r[wr_ptr_r] <= push_desc;
      cnt_r[wr_ptr_r]  <= push_count;
    end
  end

  assign head_desc  = desc_r[rd_ptr_r];
  assign head_count = cnt_r[rd_ptr_r];

endmodule

// ===== src/fra_back.sv =====
// Back end: checks each finished packet, tracks the frame and emits results.
module fra_back import fra_pkg::*; #(
  parameter int PACKET_BYTES = 64,
  parameter int CW = $clog2(PACKET_BYTES + 1),
  parameter int AW = $clog2(2 * PACKET_BYTES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic          q_valid,
  input  desc_t         q_desc,
  input  logic [CW-1:0] q_count,
  output logic          q_pop,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  output logic          out_valid,
  output out_item_t     out_item,
  input  logic          out_pop
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SINGLE = 4'b0010,
    S_READ   = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic          in_frame_r, in_frame_nxt;
  logic [15:0]   exp_r, exp_nxt;
  logic [15:0]   rc_r, rc_nxt;
  logic [15:0]   flags_r, flags_nxt;
  logic [31:0]   seq_r, seq_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic [15:0]   off_r, off_nxt;
  logic [1:0]    st_r, st_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  logic          open_frame;
  logic          hdr_match;
  logic          hdr_bad;
  logic          over_limit;
  logic [15:0]   hdr_len, hdr_flags;
  logic [31:0]   hdr_seq;
  logic [CW-1:0] start_cnt, plen;
  logic [15:0]   eff_exp, eff_rc;
  logic [16:0]   sum;
  logic          overrun;
  logic          slot_free;
  logic          last_byte;

  assign open_frame = !in_frame_r;
  assign hdr_match  = (q_desc.hdr[0] == cfg.magic_first) &&
                      (q_desc.hdr[1] == cfg.magic_second) &&
                      (q_desc.hdr[2] == cfg.proto_version) &&
                      (q_desc.hdr[3] == cfg.frame_type);
  assign hdr_len    = {q_desc.hdr[4], q_desc.hdr[5]};
  assign hdr_flags  = {q_desc.hdr[6], q_desc.hdr[7]};
  assign hdr_seq    = {q_desc.hdr[8], q_desc.hdr[9], q_desc.hdr[10], q_desc.hdr[11]};
  assign hdr_bad    = open_frame && ((q_count < CW'(HDR_BYTES)) || !hdr_match);
  assign over_limit = open_frame && (hdr_len > cfg.frame_limit);
  assign start_cnt  = open_frame ? CW'(HDR_BYTES) : '0;
  assign plen       = q_count - start_cnt;
  assign eff_exp    = open_frame ? hdr_len : exp_r;
  assign eff_rc     = open_frame ? 16'd0 : rc_r;
  assign sum        = {1'b0, eff_rc} + 17'(plen);
  assign overrun    = sum > {1'b0, eff_exp};
  assign slot_free  = !out_valid_r || out_pop;
  assign last_byte  = left_r == CW'(1);

  always_comb begin
    state_nxt     = state_r;
    in_frame_nxt  = in_frame_r;
    exp_nxt       = exp_r;
    rc_nxt        = rc_r;
    flags_nxt     = flags_r;
    seq_nxt       = seq_r;
    pos_nxt       = pos_r;
    left_nxt      = left_r;
    off_nxt       = off_r;
    st_nxt        = st_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_pop;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          st_nxt    = ST_ERROR;
          state_nxt = S_SINGLE;
          if (q_desc.overlong || hdr_bad) begin
            st_nxt = ST_ERROR;
          end else if (over_limit) begin
            exp_nxt   = hdr_len;
            flags_nxt = hdr_flags;
            seq_nxt   = hdr_seq;
            rc_nxt    = 16'd0;
          end else if (overrun) begin
            in_frame_nxt = 1'b0;
            exp_nxt      = 16'd0;
            rc_nxt       = 16'd0;
            flags_nxt    = 16'd0;
            seq_nxt      = 32'd0;
          end else begin
            exp_nxt = eff_exp;
            rc_nxt  = sum[15:0];
            if (open_frame) begin
              flags_nxt = hdr_flags;
              seq_nxt   = hdr_seq;
            end
            in_frame_nxt = sum[15:0] != eff_exp;
            st_nxt       = (sum[15:0] == eff_exp) ? ST_DONE : ST_MORE;
            if (plen != '0) begin
              pos_nxt   = q_desc.bank ? AW'(PACKET_BYTES) + AW'(start_cnt) : AW'(start_cnt);
              left_nxt  = plen;
              off_nxt   = eff_rc;
              state_nxt = S_READ;
            end
          end
        end
      end
      S_SINGLE: begin
        if (slot_free) begin
          out_nxt.data_valid   = 1'b0;
          out_nxt.data_byte    = 8'd0;
          out_nxt.data_offset  = 16'd0;
          out_nxt.run_last     = 1'b1;
          out_nxt.status       = st_r;
          out_nxt.frame_length = exp_r;
          out_nxt.frame_flags  = flags_r;
          out_nxt.frame_seq    = seq_r;
          out_valid_nxt        = 1'b1;
          q_pop                = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_nxt.data_valid   = 1'b1;
          out_nxt.data_byte    = rd_data;
          out_nxt.data_offset  = off_r;
          out_nxt.run_last     = last_byte;
          out_nxt.status       = last_byte ? st_r : ST_MORE;
          out_nxt.frame_length = exp_r;
          out_nxt.frame_flags  = flags_r;
          out_nxt.frame_seq    = seq_r;
          out_valid_nxt        = 1'b1;
          off_nxt              = off_r + 16'd1;
          left_nxt             = left_r - CW'(1);
          pos_nxt              = pos_r + AW'(1);
          if (last_byte) begin
            q_pop     = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_frame_r  <= 1'b0;
      exp_r       <= 16'd0;
      rc_r        <= 16'd0;
      flags_r     <= 16'd0;
      seq_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_frame_r  <= in_frame_nxt;
      exp_r       <= exp_nxt;
      rc_r        <= rc_nxt;
      flags_r     <= flags_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    left_r <= left_nxt;
    off_r  <= off_nxt;
    st_r   <= st_nxt;
    out_r  <= out_nxt;
  end

  assign rd_addr   = pos_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== src/frame_reassembler_rx.sv =====
// Top level of the frame reassembler: configuration, front end, bank queue, back end.
//
//   Channel   Ports                              Transfer when
//   input     in_push, in_full, in_data          in_push && !in_full
//   result    out_empty, out_pop, out_data       out_pop && !out_empty
//   config    cfg_we, cfg_index, cfg_data        cfg_we
//
// Bytes are taken one per cycle, while in_full is low, into one of two packet banks of a RAM.
// At a packet end the back end checks the packet in S_IDLE, then emits each payload result
// via S_READ (RAM read) and S_EMIT (output register), or a single result via S_SINGLE.
// in_full rises while both banks hold packets that the back end has not finished.
// Reset is synchronous and active low; no clearing pass is needed.
module frame_reassembler_rx import fra_pkg::*; #(
  parameter int PACKET_BYTES = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  in_item_t              in_data,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(PACKET_BYTES + 1);
  localparam int AW = $clog2(2 * PACKET_BYTES);

  cfg_t          cfg_r, cfg_nxt;
  logic          q_push, q_full, q_pop, q_valid;
  desc_t         q_in_desc, q_head_desc;
  logic [CW-1:0] q_in_count, q_head_count;
  logic          ram_wr_en, ram_rd_en;
  logic [AW-1:0] ram_wr_addr, ram_rd_addr;
  logic [7:0]    ram_wr_data, ram_rd_data;
  logic          out_valid;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MAGIC_FIRST:  cfg_nxt.magic_first   = cfg_data[7:0];
        CFG_MAGIC_SECOND: cfg_nxt.magic_second  = cfg_data[7:0];
        CFG_PROTO_VER:    cfg_nxt.proto_version = cfg_data[7:0];
        CFG_FRAME_TYPE:   cfg_nxt.frame_type    = cfg_data[7:0];
        CFG_FRAME_LIMIT:  cfg_nxt.frame_limit   = cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic_first   <= 8'd0;
      cfg_r.magic_second  <= 8'd0;
      cfg_r.proto_version <= 8'd0;
      cfg_r.frame_type    <= 8'd0;
      cfg_r.frame_limit   <= FRAME_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fra_front #(
    .PACKET_BYTES(PACKET_BYTES),
    .CW(CW),
    .AW(AW)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_data(in_data),
    .q_full(q_full),
    .q_push(q_push),
    .q_desc(q_in_desc),
    .q_count(q_in_count),
    .ram_wr_en(ram_wr_en),
    .ram_wr_addr(ram_wr_addr),
    .ram_wr_data(ram_wr_data)
  );

  fra_desc_queue #(
    .CW(CW)
  ) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .push_desc(q_in_desc),
    .push_count(q_in_count),
    .full(q_full),
    .pop(q_pop),
    .valid(q_valid),
    .head_desc(q_head_desc),
    .head_count(q_head_count)
  );

  fra_ram #(
    .WIDTH(8),
    .DEPTH(2 * PACKET_BYTES)
  ) u_ram (
    .clk(clk),
    .wr_en(ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en(ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  fra_back #(
    .PACKET_BYTES(PACKET_BYTES),
    .CW(CW),
    .AW(AW)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg_r),
    .q_valid(q_valid),
    .q_desc(q_head_desc),
    .q_count(q_head_count),
    .q_pop(q_pop),
    .rd_en(ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data),
    .out_valid(out_valid),
    .out_item(out_data),
    .out_pop(out_pop)
  );

  assign in_full   = q_full;
  assign out_empty = !out_valid;

endmodule

// ===== src/fra_checker.sv =====
// Port-level checker for the frame reassembler and its bind.
`include "frame_reassembler_rx_assert.svh"

module fra_checker import fra_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_empty,
  input logic      out_pop,
  input out_item_t out_data
);

  logic shown;
  logic payload_clear;
  logic is_error;

  assign shown         = !out_empty;
  assign payload_clear = out_data.run_last && out_data.data_byte == 8'd0 &&
                         out_data.data_offset == 16'd0;
  assign is_error      = out_data.status == ST_ERROR;

  `FRA_ASSERT_NEXT(a_held_result, shown && !out_pop, shown && $stable(out_data))
  `FRA_ASSERT_SAME(a_no_payload_shape, shown && !out_data.data_valid, payload_clear)
  `FRA_ASSERT_SAME(a_status_on_last, shown && !out_data.run_last, out_data.status == ST_MORE)
  `FRA_ASSERT_SAME(a_error_alone, shown && is_error, !out_data.data_valid && out_data.run_last)

endmodule

bind frame_reassembler_rx fra_checker u_fra_checker (.*);

// ===== tb/sv/tb_frame_reassembler_rx.sv =====
// Self-checking testbench that streams packet bytes into the frame reassembler and checks every result.
module tb_frame_reassembler_rx import fra_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PKT_BYTES   = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 20;

  typedef logic [7:0] byte_q_t[$];

  class reassembly_tracker;
    cfg_t regs;
    logic [7:0] pkt_buf [PKT_BYTES];
    int unsigned pkt_len;
    bit too_long;
    bit frame_open;
    logic [15:0] frame_len;
    logic [15:0] got_len;
    logic [15:0] hdr_flags;
    logic [31:0] hdr_seq;
    logic [7:0] hdr_type;
    out_item_t pending_results[$];
    int errors;

    function new();
      regs = '0;
      regs.frame_limit = FRAME_LIMIT_RST;
      pkt_len = 0;
      too_long = 1'b0;
      errors = 0;
      drop_frame();
    endfunction

    function void drop_frame();
      frame_open = 1'b0;
      frame_len = '0;
      got_len = '0;
      hdr_flags = '0;
      hdr_seq = '0;
      hdr_type = '0;
    endfunction

    function void add_result(bit valid, logic [7:0] b, logic [15:0] off, bit last,
                             logic [1:0] st);
      out_item_t r;
      r.data_valid = valid;
      r.data_byte = b;
      r.data_offset = off;
      r.run_last = last;
      r.status = st;
      r.frame_length = frame_len;
      r.frame_flags = hdr_flags;
      r.frame_seq = hdr_seq;
      pending_results.push_back(r);
    endfunction

    function void end_packet();
      int start;
      int plen;
      int base;
      logic [1:0] st;
      start = 0;
      if (too_long) begin
        add_result(1'b0, '0, '0, 1'b1, ST_ERROR);
        return;
      end
      if (!frame_open) begin
        if (pkt_len < HDR_BYTES || pkt_buf[0] != regs.magic_first ||
            pkt_buf[1] != regs.magic_second || pkt_buf[2] != regs.proto_version ||
            pkt_buf[3] != regs.frame_type) begin
          add_result(1'b0, '0, '0, 1'b1, ST_ERROR);
          return;
        end
        hdr_type = pkt_buf[3];
        frame_len = {pkt_buf[4], pkt_buf[5]};
        hdr_flags = {pkt_buf[6], pkt_buf[7]};
        hdr_seq = {pkt_buf[8], pkt_buf[9], pkt_buf[10], pkt_buf[11]};
        got_len = '0;
        if (frame_len > regs.frame_limit) begin
          add_result(1'b0, '0, '0, 1'b1, ST_ERROR);
          return;
        end
        start = HDR_BYTES;
        frame_open = 1'b1;
      end
      plen = int'(pkt_len) - start;
      if (int'(got_len) + plen > int'(frame_len)) begin
        drop_frame();
        add_result(1'b0, '0, '0, 1'b1, ST_ERROR);
        return;
      end
      base = int'(got_len);
      got_len = 16'(base + plen);
      if (got_len == frame_len) begin
        frame_open = 1'b0;
        st = ST_DONE;
      end else begin
        st = ST_MORE;
      end
      if (plen == 0) add_result(1'b0, '0, '0, 1'b1, st);
      for (int i = 0; i < plen; i++) begin
        add_result(1'b1, pkt_buf[start + i], 16'(base + i), i == plen - 1,
                   (i == plen - 1) ? st : ST_MORE);
      end
    endfunction

    function void take_byte(in_item_t it);
      if (pkt_len < PKT_BYTES) begin
        pkt_buf[pkt_len] = it.packet_byte;
        pkt_len++;
      end else begin
        too_long = 1'b1;
      end
      if (it.packet_last) begin
        end_packet();
        pkt_len = 0;
        too_long = 1'b0;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void match_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("data_valid", 32'(want.data_valid), 32'(got.data_valid));
      compare_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
      compare_field("data_offset", 32'(want.data_offset), 32'(got.data_offset));
      compare_field("run_last", 32'(want.run_last), 32'(got.run_last));
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("frame_length", 32'(want.frame_length), 32'(got.frame_length));
      compare_field("frame_flags", 32'(want.frame_flags), 32'(got.frame_flags));
      compare_field("frame_seq", want.frame_seq, got.frame_seq);
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MAGIC_FIRST;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  reassembly_tracker tracker = new();
  bit idle_on = 1'b1;
  int bytes_sent = 0;

  frame_reassembler_rx #(.PACKET_BYTES(PKT_BYTES)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_data(in_data),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void add_random(ref byte_q_t q, input int n);
    for (int i = 0; i < n; i++) q.push_back(8'($urandom));
  endfunction

  function automatic byte_q_t frame_header(cfg_t c, logic [15:0] len, logic [15:0] flg,
                                           logic [31:0] sq);
    byte_q_t q;
    q = '{c.magic_first, c.magic_second, c.proto_version, c.frame_type,
          len[15:8], len[7:0], flg[15:8], flg[7:0], sq[31:24], sq[23:16], sq[15:8], sq[7:0]};
    return q;
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    in_item_t item;
    item = '{packet_byte: b, packet_last: last};
    if (idle_on && $urandom_range(0, 15) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_full);
    tracker.take_byte(item);
    bytes_sent++;
  endtask

  task automatic send_packet(byte_q_t pkt);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic send_random(int n);
    byte_q_t pkt;
    add_random(pkt, n);
    send_packet(pkt);
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_regs(cfg_t c);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    idx = '{CFG_MAGIC_FIRST, CFG_MAGIC_SECOND, CFG_PROTO_VER, CFG_FRAME_TYPE, CFG_FRAME_LIMIT};
    val = '{16'(c.magic_first), 16'(c.magic_second), 16'(c.proto_version),
            16'(c.frame_type), c.frame_limit};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    tracker.regs = c;
  endtask

  task automatic run_frame();
    int len;
    int k;
    int remaining;
    byte_q_t pkt;
    case ($urandom_range(0, 9))
      7, 8: len = $urandom_range(121, 300);
      9: len = $urandom_range(0, 3);
      default: len = $urandom_range(0, 120);
    endcase
    if (len > int'(tracker.regs.frame_limit)) len = tracker.regs.frame_limit;
    k = $urandom_range(0, len < 52 ? len : 52);
    pkt = frame_header(tracker.regs, 16'(len), 16'($urandom), $urandom);
    add_random(pkt, k);
    send_packet(pkt);
    remaining = len - k;
    while (remaining > 0) begin
      if ($urandom_range(0, 11) == 0) send_random($urandom_range(65, 72));
      if (remaining < PKT_BYTES && $urandom_range(0, 9) == 0) begin
        send_random(remaining + $urandom_range(1, PKT_BYTES - remaining));
        remaining = 0;
      end else begin
        k = $urandom_range(1, remaining < PKT_BYTES ? remaining : PKT_BYTES);
        send_random(k);
        remaining -= k;
      end
    end
  endtask

  task automatic send_noise();
    byte_q_t pkt;
    int lim;
    int len;
    int j;
    lim = tracker.regs.frame_limit;
    case ($urandom_range(0, 4))
      0: send_random($urandom_range(1, HDR_BYTES - 1));
      1: begin
        pkt = frame_header(tracker.regs, 16'($urandom), 16'($urandom), $urandom);
        add_random(pkt, $urandom_range(0, 8));
        j = $urandom_range(0, 3);
        pkt[j] = ~pkt[j];
        send_packet(pkt);
      end
      2: begin
        if (lim < 65535) begin
          pkt = frame_header(tracker.regs, 16'($urandom_range(lim + 1, 65535)),
                             16'($urandom), $urandom);
          add_random(pkt, $urandom_range(0, 4));
          send_packet(pkt);
        end else begin
          send_random($urandom_range(1, HDR_BYTES - 1));
        end
      end
      3: send_random($urandom_range(PKT_BYTES + 1, PKT_BYTES + 8));
      default: begin
        len = $urandom_range(0, lim < 20 ? lim : 20);
        pkt = frame_header(tracker.regs, 16'(len), 16'($urandom), $urandom);
        add_random(pkt, len + $urandom_range(1, PKT_BYTES - HDR_BYTES - len));
        send_packet(pkt);
      end
    endcase
  endtask

  task automatic random_traffic(int count);
    int goal;
    goal = bytes_sent + count;
    while (bytes_sent < goal) begin
      if ($urandom_range(0, 3) == 0) send_noise();
      else run_frame();
    end
  endtask

  task automatic directed_cases();
    byte_q_t pkt;
    pkt = frame_header(tracker.regs, 16'd3, 16'h0000, 32'h0000_0000);
    pkt.push_back(8'hFF);
    pkt.push_back(8'h00);
    pkt.push_back(8'hA5);
    send_packet(pkt);
    wait_idle();
    program_regs('{magic_first: 8'h5A, magic_second: 8'hC3, proto_version: 8'h01,
                   frame_type: 8'h7E, frame_limit: 16'h0000});
    send_packet(frame_header(tracker.regs, 16'd0, 16'hA5A5, 32'h8000_0001));
    send_packet(frame_header(tracker.regs, 16'd1, 16'h0001, 32'h0000_0002));
    pkt = '{8'hFF};
    send_packet(pkt);
    for (int j = 0; j < 4; j++) begin
      pkt = frame_header(tracker.regs, 16'd0, 16'h0000, 32'h0);
      pkt[j] = ~pkt[j];
      send_packet(pkt);
    end
    wait_idle();
    program_regs('{magic_first: 8'h5A, magic_second: 8'hC3, proto_version: 8'h01,
                   frame_type: 8'h7E, frame_limit: 16'hFFFE});
    send_packet(frame_header(tracker.regs, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_packet(frame_header(tracker.regs, 16'd10, 16'h1234, 32'h0BAD_F00D));
    send_random(4);
    send_random(PKT_BYTES + 2);
    send_random(7);
    pkt = frame_header(tracker.regs, 16'd52, 16'h8001, 32'h7FFF_FFFF);
    add_random(pkt, PKT_BYTES - HDR_BYTES);
    send_packet(pkt);
    wait_idle();
  endtask

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) tracker.match_result(out_data);
      if (stall > 0) begin
        stall--;
        out_pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
        stall = $urandom_range(0, 10);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_cases();
    program_regs('{magic_first: 8'hFF, magic_second: 8'hFF, proto_version: 8'hFF,
                   frame_type: 8'hFF, frame_limit: 16'hFFFF});
    random_traffic(20);
    wait_idle();
    program_regs('{magic_first: 8'($urandom), magic_second: 8'($urandom),
                   proto_version: 8'($urandom), frame_type: 8'($urandom),
                   frame_limit: 16'($urandom_range(40, 200))});
    random_traffic(20);
    wait_idle();
    program_regs('{magic_first: 8'h00, magic_second: 8'($urandom),
                   proto_version: 8'($urandom), frame_type: 8'h00,
                   frame_limit: FRAME_LIMIT_RST});
    idle_on = 1'b0;
    random_traffic(10);
    wait_idle();
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+src
src/fra_pkg.sv
src/fra_ram.sv
src/fra_front.sv
src/fra_desc_queue.sv
src/fra_back.sv
src/frame_reassembler_rx.sv
src/fra_checker.sv
tb/sv/tb_frame_reassembler_rx.sv
